FILE: rtl/core/c2rb_pkg.sv
// Shared types, constants and tables for the range/bearing CORDIC.
// No dependencies; imported by every module of the block.
`default_nettype none

package c2rb_pkg;

   // Guard bits below the input scale in the x/y datapath
   localparam int GUARD_BITS = 16;
   // Fraction bits of the angle accumulator and of the gain constant
   localparam int ANGLE_FRAC = 30;
   localparam int GAIN_FRAC  = 30;
   // Angle accumulator width: +-(pi + sum of arctangents) in Q30 fits 34 bits
   localparam int Z_WIDTH    = 34;
   // Result angle width and the width after dropping 17 fraction bits
   localparam int BEARING_WIDTH = 16;
   localparam int BEAR_SHIFT    = 17;
   localparam int BEAR_ACC_W    = Z_WIDTH + 1 - BEAR_SHIFT;

   localparam logic signed [Z_WIDTH-1:0]       Z_PI          = 34'sd3373259426;
   localparam logic signed [BEARING_WIDTH-1:0] BEAR_VAL_PI   = 16'sd25736;
   localparam logic signed [BEARING_WIDTH-1:0] BEAR_VAL_HALF = 16'sd12868;
   localparam logic signed [BEAR_ACC_W-1:0]    BEAR_ACC_MAX  = 18'sd25736;

   // Fixed bearing for inputs that lie on an axis
   typedef enum logic [1:0] {
      BEAR_ZERO,
      BEAR_PI,
      BEAR_POS_HALF,
      BEAR_NEG_HALF
   } bear_sel_type;

   // Control that travels with each request down the pipeline
   typedef struct packed {
      logic         valid;
      logic         special;
      bear_sel_type sel;
   } ctl_type;

   // atan(2^-i) in Q30, rounded to nearest
   function automatic logic signed [Z_WIDTH-1:0] atan_q30(input int idx);
      logic signed [Z_WIDTH-1:0] val;
      case (idx)
         0:       val = 34'sd843314857;
         1:       val = 34'sd497837829;
         2:       val = 34'sd263043837;
         3:       val = 34'sd133525159;
         4:       val = 34'sd67021687;
         5:       val = 34'sd33543516;
         6:       val = 34'sd16775851;
         7:       val = 34'sd8388437;
         8:       val = 34'sd4194283;
         9:       val = 34'sd2097149;
         10:      val = 34'sd1048576;
         11:      val = 34'sd524288;
         12:      val = 34'sd262144;
         13:      val = 34'sd131072;
         14:      val = 34'sd65536;
         15:      val = 34'sd32768;
         16:      val = 34'sd16384;
         17:      val = 34'sd8192;
         18:      val = 34'sd4096;
         19:      val = 34'sd2048;
         20:      val = 34'sd1024;
         21:      val = 34'sd512;
         22:      val = 34'sd256;
         23:      val = 34'sd128;
         24:      val = 34'sd64;
         25:      val = 34'sd32;
         26:      val = 34'sd16;
         27:      val = 34'sd8;
         28:      val = 34'sd4;
         29:      val = 34'sd2;
         30:      val = 34'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Inverse CORDIC gain in Q30; counts of 16 and above share one value
   function automatic logic [GAIN_FRAC-1:0] gain_q30(input int iters);
      logic [GAIN_FRAC-1:0] val;
      case (iters)
         8:       val = 30'd652039507;
         9:       val = 30'd652034532;
         10:      val = 30'd652033289;
         11:      val = 30'd652032978;
         12:      val = 30'd652032900;
         13:      val = 30'd652032881;
         14:      val = 30'd652032876;
         15:      val = 30'd652032874;
         default: val = 30'd652032874;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/c2rb_pre.sv
// Input stage: axis detection, left half-plane fold and guard-bit scaling.
// Depends on c2rb_pkg.
`default_nettype none

module c2rb_pre #(
   parameter int  COORD_WIDTH = 16,
   localparam int DW          = COORD_WIDTH + c2rb_pkg::GUARD_BITS + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic signed [COORD_WIDTH-1:0]         pos_x,
   input  logic signed [COORD_WIDTH-1:0]         pos_y,
   output c2rb_pkg::ctl_type                     ctl_out,
   output logic signed [DW-1:0]                  x_out,
   output logic signed [DW-1:0]                  y_out,
   output logic signed [c2rb_pkg::Z_WIDTH-1:0]   z_out,
   output logic        [COORD_WIDTH-1:0]         spec_out
);
   import c2rb_pkg::*;

   logic signed [DW-1:0]          xe, ye, x_abs, y_adj;
   logic        [COORD_WIDTH:0]   xw, yw, ax, ay;
   logic                          x_neg, y_neg, x_zero, y_zero;

   ctl_type                       ctl_in, ctl_ff;
   logic signed [DW-1:0]          x_in, x_ff, y_in, y_ff;
   logic signed [Z_WIDTH-1:0]     z_in, z_ff;
   logic        [COORD_WIDTH-1:0] spec_in, spec_ff;

   // Fold the left half-plane onto the right and seed the angle with +-pi
   always_comb begin
      x_neg  = pos_x[COORD_WIDTH-1];
      y_neg  = pos_y[COORD_WIDTH-1];
      x_zero = (pos_x == '0);
      y_zero = (pos_y == '0);
      xe     = {{(DW-COORD_WIDTH){pos_x[COORD_WIDTH-1]}}, pos_x};
      ye     = {{(DW-COORD_WIDTH){pos_y[COORD_WIDTH-1]}}, pos_y};
      x_abs  = x_neg ? -xe : xe;
      y_adj  = x_neg ? -ye : ye;
      x_in   = {x_abs[DW-1-GUARD_BITS:0], {GUARD_BITS{1'b0}}};
      y_in   = {y_adj[DW-1-GUARD_BITS:0], {GUARD_BITS{1'b0}}};
      z_in   = x_neg ? (y_neg ? -Z_PI : Z_PI) : '0;
   end

   // Exact answers for points on an axis
   always_comb begin
      xw      = {pos_x[COORD_WIDTH-1], pos_x};
      yw      = {pos_y[COORD_WIDTH-1], pos_y};
      ax      = x_neg ? -xw : xw;
      ay      = y_neg ? -yw : yw;
      spec_in = y_zero ? ax[COORD_WIDTH-1:0] : ay[COORD_WIDTH-1:0];
      ctl_in.valid   = in_valid;
      ctl_in.special = x_zero | y_zero;
      if (y_zero) begin
         ctl_in.sel = x_neg ? BEAR_PI : BEAR_ZERO;
      end else begin
         ctl_in.sel = y_neg ? BEAR_NEG_HALF : BEAR_POS_HALF;
      end
   end

   // Advance the stage with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         spec_ff <= spec_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign spec_out = spec_ff;

endmodule

`default_nettype wire

FILE: rtl/core/c2rb_iter.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on c2rb_pkg for the arctangent table and the control struct.
`default_nettype none

module c2rb_iter #(
   parameter int  COORD_WIDTH = 16,
   parameter int  ITER_INDEX  = 0,
   localparam int DW          = COORD_WIDTH + c2rb_pkg::GUARD_BITS + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  c2rb_pkg::ctl_type                     ctl_in,
   input  logic signed [DW-1:0]                  x_in,
   input  logic signed [DW-1:0]                  y_in,
   input  logic signed [c2rb_pkg::Z_WIDTH-1:0]   z_in,
   input  logic        [COORD_WIDTH-1:0]         spec_in,
   output c2rb_pkg::ctl_type                     ctl_out,
   output logic signed [DW-1:0]                  x_out,
   output logic signed [DW-1:0]                  y_out,
   output logic signed [c2rb_pkg::Z_WIDTH-1:0]   z_out,
   output logic        [COORD_WIDTH-1:0]         spec_out
);
   import c2rb_pkg::*;

   localparam logic signed [Z_WIDTH-1:0] ATAN = atan_q30(ITER_INDEX);

   logic signed [DW-1:0]          dx, dy;
   ctl_type                       ctl_ff;
   logic signed [DW-1:0]          x_nx_in, x_ff, y_nx_in, y_ff;
   logic signed [Z_WIDTH-1:0]     z_nx_in, z_ff;
   logic        [COORD_WIDTH-1:0] spec_ff;

   // Rotate towards the x axis; the sign of y picks the direction
   always_comb begin
      dx = y_in >>> ITER_INDEX;
      dy = x_in >>> ITER_INDEX;
      if (!y_in[DW-1]) begin
         x_nx_in = x_in + dx;
         y_nx_in = y_in - dy;
         z_nx_in = z_in + ATAN;
      end else begin
         x_nx_in = x_in - dx;
         y_nx_in = y_in + dy;
         z_nx_in = z_in - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
      if (adv) begin
         x_ff    <= x_nx_in;
         y_ff    <= y_nx_in;
         z_ff    <= z_nx_in;
         spec_ff <= spec_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign spec_out = spec_ff;

endmodule

`default_nettype wire

FILE: rtl/core/c2rb_post.sv
// Output stages: gain correction and rounding of range, rounding and
// clamping of bearing, axis overrides. Depends on c2rb_pkg.
`default_nettype none

module c2rb_post #(
   parameter int  COORD_WIDTH = 16,
   parameter int  ITERATIONS  = 16,
   localparam int DW          = COORD_WIDTH + c2rb_pkg::GUARD_BITS + 3
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  c2rb_pkg::ctl_type                           ctl_in,
   input  logic signed [DW-1:0]                        x_in,
   input  logic signed [c2rb_pkg::Z_WIDTH-1:0]         z_in,
   input  logic        [COORD_WIDTH-1:0]               spec_in,
   output logic                                        valid_out,
   output logic        [COORD_WIDTH-1:0]               range_out,
   output logic signed [c2rb_pkg::BEARING_WIDTH-1:0]   bearing_out
);
   import c2rb_pkg::*;

   // Magnitude split so that each product stays under 32 bits a side
   localparam int LO_W   = 24;
   localparam int HI_W   = DW - 1 - LO_W;
   localparam int FW     = DW - 1 + GAIN_FRAC;
   localparam int RSHIFT = GAIN_FRAC + GUARD_BITS;
   localparam logic [GAIN_FRAC-1:0] GAIN = gain_q30(ITERATIONS);
   localparam logic [FW:0] RND = {{(FW-RSHIFT+1){1'b0}}, 1'b1, {(RSHIFT-1){1'b0}}};

   logic        [DW-2:0]             ux;
   logic signed [Z_WIDTH:0]          z_rnd;
   logic signed [BEAR_ACC_W-1:0]     b_acc;
   logic        [FW:0]               full;

   ctl_type                          ctl_a_ff;
   logic        [LO_W+GAIN_FRAC-1:0] plo_in, plo_ff;
   logic        [HI_W+GAIN_FRAC-1:0] phi_in, phi_ff;
   logic signed [BEARING_WIDTH-1:0]  brg_in, brg_ff;
   logic        [COORD_WIDTH-1:0]    spec_ff;
   logic                             vld_ff;
   logic        [COORD_WIDTH-1:0]    rng_in, rng_ff;
   logic signed [BEARING_WIDTH-1:0]  brg_out_ff;

   // First stage: partial products of the gain, bearing round and clamp
   always_comb begin
      ux     = x_in[DW-1] ? '0 : x_in[DW-2:0];
      plo_in = ux[LO_W-1:0] * GAIN;
      phi_in = ux[DW-2:LO_W] * GAIN;
      z_rnd  = {z_in[Z_WIDTH-1], z_in} + (Z_WIDTH+1)'(1 << (BEAR_SHIFT - 1));
      b_acc  = z_rnd[Z_WIDTH:BEAR_SHIFT];
      if (ctl_in.special) begin
         case (ctl_in.sel)
            BEAR_ZERO:     brg_in = '0;
            BEAR_PI:       brg_in = BEAR_VAL_PI;
            BEAR_POS_HALF: brg_in = BEAR_VAL_HALF;
            BEAR_NEG_HALF: brg_in = -BEAR_VAL_HALF;
            default:       brg_in = '0;
         endcase
      end else if (b_acc > BEAR_ACC_MAX) begin
         brg_in = BEAR_VAL_PI;
      end else if (b_acc < -BEAR_ACC_MAX) begin
         brg_in = -BEAR_VAL_PI;
      end else begin
         brg_in = b_acc[BEARING_WIDTH-1:0];
      end
   end

   // Second stage: join the products, drop gain and guard fractions
   always_comb begin
      full   = {1'b0, phi_ff, {LO_W{1'b0}}}
             + {{(FW+1-LO_W-GAIN_FRAC){1'b0}}, plo_ff} + RND;
      rng_in = ctl_a_ff.special ? spec_ff : full[RSHIFT +: COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         vld_ff   <= 1'b0;
      end else if (adv) begin
         ctl_a_ff <= ctl_in;
         vld_ff   <= ctl_a_ff.valid;
      end
      if (adv) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         brg_ff     <= brg_in;
         spec_ff    <= spec_in;
         rng_ff     <= rng_in;
         brg_out_ff <= brg_ff;
      end
   end

   assign valid_out   = vld_ff;
   assign range_out   = rng_ff;
   assign bearing_out = brg_out_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cartesian_to_range_bearing_unit.sv
// Top level of the range/bearing unit: input fold, CORDIC pipeline,
// output stages and a two-entry result buffer. Depends on c2rb_pkg.
//
// Usage:
//   A request carries req_pos_x and req_pos_y and is taken when req_valid
//   and req_ready are both high. Each request gives one result on the rsp_
//   channel: rsp_range_out (unsigned, input scale, rounded) and
//   rsp_bearing_out (atan2 in radians times 8192, signed).
//   The pipeline takes one request every cycle while req_ready is high.
//   The accepting edge loads the input fold register; after it come the
//   CORDIC micro-rotation registers, the gain multiply and rounding
//   registers and the register that loads the result buffer.
//   A two-entry buffer holds results; while rsp_ready is low the pipeline
//   keeps accepting until the buffer is full, then req_ready drops and all
//   stages hold together, so no request is lost or repeated.
//   Synchronous reset empties the pipeline and the buffer; results are
//   held in order.
`default_nettype none

module cartesian_to_range_bearing_unit #(
   parameter int COORD_WIDTH = 16,
   parameter int ITERATIONS  = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [COORD_WIDTH-1:0]              req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]              req_pos_y,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic        [COORD_WIDTH-1:0]              rsp_range_out,
   output logic signed [c2rb_pkg::BEARING_WIDTH-1:0]  rsp_bearing_out
);
   import c2rb_pkg::*;

   localparam int DW = COORD_WIDTH + GUARD_BITS + 3;

   logic                          adv;
   ctl_type                       ctl_pipe  [ITERATIONS+1];
   logic signed [DW-1:0]          x_pipe    [ITERATIONS+1];
   logic signed [DW-1:0]          y_pipe    [ITERATIONS+1];
   logic signed [Z_WIDTH-1:0]     z_pipe    [ITERATIONS+1];
   logic        [COORD_WIDTH-1:0] spec_pipe [ITERATIONS+1];

   logic                          post_valid;
   logic        [COORD_WIDTH-1:0] post_range;
   logic signed [BEARING_WIDTH-1:0] post_bearing;

   logic                          push, pop;
   logic        [1:0]             count_in, count_ff;
   logic        [COORD_WIDTH-1:0] head_rng_ff, skid_rng_ff;
   logic signed [BEARING_WIDTH-1:0] head_brg_ff, skid_brg_ff;

   // Whole pipeline moves while the result buffer has room
   assign adv       = (count_ff != 2'd2);
   assign req_ready = adv;

   c2rb_pre #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_pre (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .ctl_out  (ctl_pipe[0]),
      .x_out    (x_pipe[0]),
      .y_out    (y_pipe[0]),
      .z_out    (z_pipe[0]),
      .spec_out (spec_pipe[0])
   );

   // One register stage per micro-rotation
   for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_iter
      c2rb_iter #(
         .COORD_WIDTH (COORD_WIDTH),
         .ITER_INDEX  (gi)
      ) u_iter (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_in   (ctl_pipe[gi]),
         .x_in     (x_pipe[gi]),
         .y_in     (y_pipe[gi]),
         .z_in     (z_pipe[gi]),
         .spec_in  (spec_pipe[gi]),
         .ctl_out  (ctl_pipe[gi+1]),
         .x_out    (x_pipe[gi+1]),
         .y_out    (y_pipe[gi+1]),
         .z_out    (z_pipe[gi+1]),
         .spec_out (spec_pipe[gi+1])
      );
   end

   c2rb_post #(
      .COORD_WIDTH (COORD_WIDTH),
      .ITERATIONS  (ITERATIONS)
   ) u_post (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .ctl_in      (ctl_pipe[ITERATIONS]),
      .x_in        (x_pipe[ITERATIONS]),
      .z_in        (z_pipe[ITERATIONS]),
      .spec_in     (spec_pipe[ITERATIONS]),
      .valid_out   (post_valid),
      .range_out   (post_range),
      .bearing_out (post_bearing)
   );

   // Result buffer: head drives the channel, skid catches one more request
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid & rsp_ready;
   assign push      = adv & post_valid;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      if (pop && count_ff == 2'd2) begin
         head_rng_ff <= skid_rng_ff;
         head_brg_ff <= skid_brg_ff;
      end else if (push && (count_ff == 2'd0 || (pop && count_ff == 2'd1))) begin
         head_rng_ff <= post_range;
         head_brg_ff <= post_bearing;
      end
      if (push && !pop && count_ff == 2'd1) begin
         skid_rng_ff <= post_range;
         skid_brg_ff <= post_bearing;
      end
   end

   assign rsp_range_out   = head_rng_ff;
   assign rsp_bearing_out = head_brg_ff;

   // Buffer occupancy never exceeds two entries
   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   // A held result is never dropped from the buffer
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (count_ff >= $past(count_ff)))
      else $error("result lost while receiver stalled");

   // Delivered bearing stays within plus or minus pi
   a_bearing_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing_out <= BEAR_VAL_PI && rsp_bearing_out >= -BEAR_VAL_PI))
      else $error("bearing outside plus or minus pi");

endmodule

`default_nettype wire
